// ----- hw/rtl/gpc_pkg.sv -----
// ----------------------------------------------------------------------------
// gpc_pkg
// shared types and codes of the geofence polygon checker
// ----------------------------------------------------------------------------
package gpc_pkg;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_FENCE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_ZERO_VTX  = 2'd3
  } status_t;

  localparam logic [2:0] CFG_ALT_FLOOR   = 3'd0;
  localparam logic [2:0] CFG_ALT_CEILING = 3'd1;
  localparam logic [2:0] CFG_HOME_ALT    = 3'd2;
  localparam logic [2:0] CFG_HOME_VALID  = 3'd3;
  localparam logic [2:0] CFG_MAX_HEIGHT  = 3'd4;

  // classified command as it travels from front to back
  typedef struct packed {
    op_t                op;
    logic [7:0]         vertex_index;
    logic signed [30:0] coord_lat;
    logic signed [31:0] coord_lon;
    logic signed [27:0] altitude;
    logic               fence_kind;
    logic [8:0]         poly_len;
    logic               idx_oob;
    logic               span_bad;
    logic               cnt_zero;
  } cmd_t;

  typedef struct packed {
    logic signed [27:0] alt_floor;
    logic signed [27:0] alt_ceiling;
    logic signed [27:0] home_alt;
    logic               home_valid;
    logic [26:0]        max_height;
  } cfg_t;

endpackage

// ----- hw/rtl/gpc_front.sv -----
// ----------------------------------------------------------------------------
// gpc_front
// takes items, decodes the operation and precomputes range checks
// ----------------------------------------------------------------------------
module gpc_front #(
  parameter int VERTEX_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [1:0]         op,
  input  logic [7:0]         vertex_index,
  input  logic signed [30:0] coord_lat,
  input  logic signed [31:0] coord_lon,
  input  logic signed [27:0] altitude,
  input  logic               fence_kind,
  input  logic [8:0]         poly_len,
  input  logic               q_full,
  output logic               push,
  output gpc_pkg::cmd_t      cmd,
  output logic               busy
);
  import gpc_pkg::*;

  logic  vld_r, vld_nxt;
  cmd_t  cmd_r, cmd_nxt;

  assign push = vld_r && !q_full;
  assign busy = vld_r && q_full;
  assign cmd  = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (push) begin
      vld_nxt = 1'b0;
    end
    if (take) begin
      vld_nxt              = 1'b1;
      cmd_nxt.op           = op_t'(op);
      cmd_nxt.vertex_index = vertex_index;
      cmd_nxt.coord_lat    = coord_lat;
      cmd_nxt.coord_lon    = coord_lon;
      cmd_nxt.altitude     = altitude;
      cmd_nxt.fence_kind   = fence_kind;
      cmd_nxt.poly_len     = poly_len;
      cmd_nxt.idx_oob      = (int'(vertex_index) >= VERTEX_DEPTH);
      cmd_nxt.span_bad     = (int'(vertex_index) + int'(poly_len) > VERTEX_DEPTH);
      cmd_nxt.cnt_zero     = (poly_len == 9'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// ----- hw/rtl/gpc_queue.sv -----
// ----------------------------------------------------------------------------
// gpc_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module gpc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gpc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output gpc_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import gpc_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head  = ent_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/gpc_back.sv -----
// ----------------------------------------------------------------------------
// gpc_back
// executes commands: vertex store, fence table, polygon walk for queries
// ----------------------------------------------------------------------------
module gpc_back #(
  parameter int VERTEX_DEPTH = 256,
  parameter int FENCE_DEPTH  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gpc_pkg::cfg_t cfg,
  input  gpc_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          pop,
  output logic          res_strobe,
  output logic          res_inside,
  output logic [1:0]    res_status
);
  import gpc_pkg::*;

  localparam int VA = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int SW = (VA > 10) ? VA : 10;
  localparam int FA = (FENCE_DEPTH > 1) ? $clog2(FENCE_DEPTH) : 1;
  localparam int TW = $clog2(FENCE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN} state_t;

  // vertex store
  logic signed [30:0] lat_mem [VERTEX_DEPTH];
  logic signed [31:0] lon_mem [VERTEX_DEPTH];
  // fence table
  logic [7:0] f_start_mem [FENCE_DEPTH];
  logic [8:0] f_len_mem   [FENCE_DEPTH];
  logic       f_excl_mem  [FENCE_DEPTH];

  state_t             state_r;
  logic [TW-1:0]      total_r;
  logic [TW-1:0]      f_r;
  logic [9:0]         k_r;
  logic signed [30:0] qlat_r;
  logic signed [31:0] qlon_r;
  logic               odd_r;
  logic               strobe_r, inside_r;
  logic [1:0]         status_r;

  // read stage
  logic               rd_v_r, rd_first_r;
  logic signed [30:0] rd_lat_r;
  logic signed [31:0] rd_lon_r;
  logic signed [30:0] prev_lat_r;
  logic signed [31:0] prev_lon_r;
  // difference stage
  logic               s1_v_r, s1_cross_r;
  logic signed [31:0] s1_a_r, s1_b_r;
  logic signed [32:0] s1_d_r, s1_c_r;
  // product stage
  logic               s2_v_r, s2_cross_r, s2_dpos_r;
  logic signed [64:0] s2_lhs_r, s2_rhs_r;

  logic [FA-1:0] f_idx;
  logic [7:0]    cur_start;
  logic [8:0]    cur_len;
  logic          cur_excl;
  logic [SW-1:0] addr_sum;
  logic [VA-1:0] rd_addr;
  logic [SW-1:0] wr_sum;
  logic          issue;
  logic          vert_ok, win_ok, walk_idle, fence_fail, hit;
  logic signed [29:0] height;
  logic [FA-1:0] new_idx;

  assign f_idx     = f_r[FA-1:0];
  assign cur_start = f_start_mem[f_idx];
  assign cur_len   = f_len_mem[f_idx];
  assign cur_excl  = f_excl_mem[f_idx];
  assign new_idx   = total_r[FA-1:0];

  assign addr_sum = (k_r == 10'd0)
                  ? SW'(cur_start) + SW'(cur_len) - SW'(1)
                  : SW'(cur_start) + SW'(k_r) - SW'(1);
  assign rd_addr  = addr_sum[VA-1:0];
  assign wr_sum   = SW'(head.vertex_index);
  assign issue    = (state_r == S_WALK);

  assign height  = 30'(head.altitude) - 30'(cfg.home_alt);
  assign vert_ok = (cfg.max_height == 27'd0) || !cfg.home_valid
                 || (height < $signed({3'b000, cfg.max_height}));
  assign win_ok  = !(cfg.alt_ceiling > cfg.alt_floor)
                 || ((head.altitude <= cfg.alt_ceiling) && (head.altitude >= cfg.alt_floor));

  assign walk_idle  = !rd_v_r && !s1_v_r && !s2_v_r;
  assign fence_fail = cur_excl ? odd_r : !odd_r;
  assign hit        = s2_dpos_r ? (s2_lhs_r <= s2_rhs_r) : (s2_lhs_r >= s2_rhs_r);

  assign pop        = (state_r == S_IDLE) && !q_empty;
  assign res_strobe = strobe_r;
  assign res_inside = inside_r;
  assign res_status = status_r;

  // stores
  always_ff @(posedge clk) begin
    if (pop && head.op == OP_VERTEX && !head.idx_oob) begin
      lat_mem[wr_sum[VA-1:0]] <= head.coord_lat;
      lon_mem[wr_sum[VA-1:0]] <= head.coord_lon;
    end
    if (pop && head.op == OP_FENCE && !head.cnt_zero && !head.span_bad
        && (int'(total_r) < FENCE_DEPTH)) begin
      f_start_mem[new_idx] <= head.vertex_index;
      f_len_mem[new_idx]   <= head.poly_len;
      f_excl_mem[new_idx]  <= head.fence_kind;
    end
    rd_lat_r <= lat_mem[rd_addr];
    rd_lon_r <= lon_mem[rd_addr];
  end

  // edge pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      s1_v_r <= rd_v_r && !rd_first_r;
      s2_v_r <= s1_v_r;
    end
    rd_first_r <= (k_r == 10'd0);
    if (rd_v_r) begin
      prev_lat_r <= rd_lat_r;
      prev_lon_r <= rd_lon_r;
    end
    s1_cross_r <= (rd_lon_r >= qlon_r) != (prev_lon_r >= qlon_r);
    s1_a_r     <= 32'(qlat_r) - 32'(rd_lat_r);
    s1_b_r     <= 32'(prev_lat_r) - 32'(rd_lat_r);
    s1_d_r     <= 33'(prev_lon_r) - 33'(rd_lon_r);
    s1_c_r     <= 33'(qlon_r) - 33'(rd_lon_r);
    s2_cross_r <= s1_cross_r;
    s2_dpos_r  <= !s1_d_r[32] && (s1_d_r != 33'sd0);
    s2_lhs_r   <= 65'(s1_a_r) * 65'(s1_d_r);
    s2_rhs_r   <= 65'(s1_b_r) * 65'(s1_c_r);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      total_r  <= '0;
      f_r      <= '0;
      k_r      <= '0;
      odd_r    <= 1'b0;
      strobe_r <= 1'b0;
      inside_r <= 1'b0;
      status_r <= ST_OK;
    end else begin
      strobe_r <= 1'b0;
      if (s2_v_r && s2_cross_r && hit) begin
        odd_r <= !odd_r;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            inside_r <= 1'b0;
            status_r <= ST_OK;
            case (head.op)
              OP_VERTEX: begin
                strobe_r <= 1'b1;
                if (head.idx_oob) begin
                  status_r <= ST_RANGE;
                end
              end
              OP_FENCE: begin
                strobe_r <= 1'b1;
                if (head.cnt_zero) begin
                  status_r <= ST_ZERO_VTX;
                end else if (head.span_bad) begin
                  status_r <= ST_RANGE;
                end else if (int'(total_r) >= FENCE_DEPTH) begin
                  status_r <= ST_FULL;
                end else begin
                  total_r <= total_r + TW'(1);
                end
              end
              OP_CLEAR: begin
                strobe_r <= 1'b1;
                total_r  <= '0;
              end
              OP_QUERY: begin
                qlat_r <= head.coord_lat;
                qlon_r <= head.coord_lon;
                if (!vert_ok) begin
                  strobe_r <= 1'b1;
                end else if (total_r == '0) begin
                  strobe_r <= 1'b1;
                  inside_r <= 1'b1;
                end else if (!win_ok) begin
                  strobe_r <= 1'b1;
                end else begin
                  f_r     <= '0;
                  k_r     <= '0;
                  odd_r   <= 1'b0;
                  state_r <= S_WALK;
                end
              end
              default: begin
                strobe_r <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          k_r <= k_r + 10'd1;
          if (k_r == 10'(cur_len)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (walk_idle) begin
            if (fence_fail) begin
              strobe_r <= 1'b1;
              inside_r <= 1'b0;
              state_r  <= S_IDLE;
            end else if (f_r + TW'(1) == total_r) begin
              strobe_r <= 1'b1;
              inside_r <= 1'b1;
              state_r  <= S_IDLE;
            end else begin
              f_r     <= f_r + TW'(1);
              k_r     <= '0;
              odd_r   <= 1'b0;
              state_r <= S_WALK;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/geofence_polygon_checker.sv -----
// ----------------------------------------------------------------------------
// geofence_polygon_checker
// polygon geofence: vertex store, fence table and even-odd query walk
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// in_       input      start & !busy        operation, index, coords, alt, kind, count
// out_      output     out_strobe, 1 cycle  inside_res, status
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// vertex write, fence define and clear pass the front register and the queue
// and each gets a strobe. a query that passes the height and window checks walks
// every fence in order, n+1 vertex reads per n-vertex fence through the single
// store read port and a drain per fence, stopping at the first failing fence.
// reset clears the fence count, the queue and the config registers; the
// vertex store and fence table hold garbage until written.
// results cannot be stalled; busy only rises while the two-entry queue is full
// and the front holds a further item.
// ----------------------------------------------------------------------------
module geofence_polygon_checker #(
  parameter int VERTEX_DEPTH = 256,
  parameter int FENCE_DEPTH  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_vertex_index,
  input  logic signed [30:0] in_coord_lat,
  input  logic signed [31:0] in_coord_lon,
  input  logic signed [27:0] in_altitude,
  input  logic               in_fence_kind,
  input  logic [8:0]         in_poly_len,
  // results
  output logic               out_strobe,
  output logic               out_inside_res,
  output logic [1:0]         out_status,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [27:0]        cfg_wdata
);
  import gpc_pkg::*;

  cfg_t cfg_r;
  cmd_t f_cmd, q_head;
  logic take, push, pop, q_empty, q_full;

  assign take = start && !busy;

  // configuration registers, to be written only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALT_FLOOR:   cfg_r.alt_floor   <= $signed(cfg_wdata);
        CFG_ALT_CEILING: cfg_r.alt_ceiling <= $signed(cfg_wdata);
        CFG_HOME_ALT:    cfg_r.home_alt    <= $signed(cfg_wdata);
        CFG_HOME_VALID:  cfg_r.home_valid  <= cfg_wdata[0];
        CFG_MAX_HEIGHT:  cfg_r.max_height  <= cfg_wdata[26:0];
        default: begin
        end
      endcase
    end
  end

  // front: decode and range checks
  gpc_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .op           (in_operation),
    .vertex_index (in_vertex_index),
    .coord_lat    (in_coord_lat),
    .coord_lon    (in_coord_lon),
    .altitude     (in_altitude),
    .fence_kind   (in_fence_kind),
    .poly_len     (in_poly_len),
    .q_full       (q_full),
    .push         (push),
    .cmd          (f_cmd),
    .busy         (busy)
  );

  // decoupling queue
  gpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (f_cmd),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: stores and polygon walk
  gpc_back #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .FENCE_DEPTH  (FENCE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (q_head),
    .q_empty    (q_empty),
    .pop        (pop),
    .res_strobe (out_strobe),
    .res_inside (out_inside_res),
    .res_status (out_status)
  );

  // a passing query always reports ok
  a_inside_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_inside_res) |-> (out_status == ST_OK))
    else $error("inside result with nonzero status");

  // the queue never takes a command while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_empty))
    else $error("queue underflow");

  // no result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

endmodule
